/* rtl/knnbc_pkg.sv */
// ----------------------------------------------------------------------------
// knnbc_pkg
// Shared codes and controller/datapath interface types for the k-nn classifier
// ----------------------------------------------------------------------------
package knnbc_pkg;

  localparam logic [1:0] CMD_TRAIN = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [4:0] NEIGHBOR_COUNT_RST = 5'd11;

  typedef struct packed {
    logic accept;
    logic start_sweep;
    logic sweep_en;
    logic start_scan;
    logic scan_en;
    logic vote_init;
    logic vote_en;
    logic load_out;
  } ctrl_t;

  typedef struct packed {
    logic query_last;
    logic need_sweep;
    logic sweep_last;
    logic issue_done;
    logic pipe_empty;
    logic vote_last;
    logic out_free;
  } stat_t;

endpackage

/* rtl/knnbc_ram.sv */
// ----------------------------------------------------------------------------
// knnbc_ram
// Generic simple dual-port RAM, one write port, one registered read port
// ----------------------------------------------------------------------------
module knnbc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/knnbc_ctrl.sv */
// ----------------------------------------------------------------------------
// knnbc_ctrl
// Sequencer: row zeroing, store scan, pipeline drain, vote and result hand-off
// ----------------------------------------------------------------------------
module knnbc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  knnbc_pkg::stat_t   stat,
  output logic               in_stall,
  output knnbc_pkg::ctrl_t   ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SWEEP  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_VOTE   = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.accept = in_valid && (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (ctl.accept) begin
          if (stat.query_last) begin
            ctl.start_scan = 1'b1;
            state_next     = S_SCAN;
          end else if (stat.need_sweep) begin
            ctl.start_sweep = 1'b1;
            state_next      = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        ctl.sweep_en = 1'b1;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_SCAN: begin
        ctl.scan_en = 1'b1;
        if (stat.issue_done) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (stat.pipe_empty) begin
          ctl.vote_init = 1'b1;
          state_next    = S_VOTE;
        end
      end
      S_VOTE: begin
        ctl.vote_en = 1'b1;
        if (stat.vote_last) state_next = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

/* rtl/knnbc_dpath.sv */
// ----------------------------------------------------------------------------
// knnbc_dpath
// Stores, distance accumulator, sorted nearest list and vote counters
// ----------------------------------------------------------------------------
module knnbc_dpath #(
  parameter int MAX_TRAIN_POINTS = 1024,
  parameter int FEATURES         = 16,
  parameter int MAX_NEIGHBORS    = 31
) (
  input  logic                clk,
  input  logic                rst,
  input  knnbc_pkg::ctrl_t    ctl,
  output knnbc_pkg::stat_t    stat,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_data,
  input  logic [1:0]          cmd,
  input  logic signed [15:0]  feature_value,
  input  logic                point_label,
  input  logic                last_feature,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                prediction,
  output logic [4:0]          neighbors_used,
  output logic                store_overflowed
);

  localparam int TAW = (MAX_TRAIN_POINTS * FEATURES > 1) ?
                       $clog2(MAX_TRAIN_POINTS * FEATURES) : 1;
  localparam int LAW = (MAX_TRAIN_POINTS > 1) ? $clog2(MAX_TRAIN_POINTS) : 1;
  localparam int CNW = $clog2(MAX_TRAIN_POINTS + 1);
  localparam int FIW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int PW  = $clog2(FEATURES + 1);
  localparam int DW  = 16 + $clog2(FEATURES);
  localparam int VIW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int CW  = $clog2(MAX_NEIGHBORS + 1);
  localparam int UW  = (CW > 5) ? CW : 5;

  // input decode
  logic is_train, is_query, is_clear, acc_train, acc_query, pos_lt, room;
  logic [PW-1:0]  pos;
  logic [CNW-1:0] count;
  logic [TAW-1:0] wbase;
  logic           overflow;
  logic [4:0]     neighbor_count;

  assign is_train  = (cmd == knnbc_pkg::CMD_TRAIN);
  assign is_query  = (cmd == knnbc_pkg::CMD_QUERY);
  assign is_clear  = (cmd == knnbc_pkg::CMD_CLEAR);
  assign acc_train = ctl.accept && is_train;
  assign acc_query = ctl.accept && is_query;
  assign pos_lt    = (pos < PW'(FEATURES));
  assign room      = (count < CNW'(MAX_TRAIN_POINTS));

  // row zeroing sweep
  logic [FIW-1:0] sw;
  logic [TAW-1:0] sbase;

  // scan issue
  logic [FIW-1:0] fi;
  logic [LAW-1:0] row;
  logic [TAW-1:0] rbase;
  logic           issue_done, iss, row_end, last_row;

  assign iss      = ctl.scan_en && !issue_done;
  assign row_end  = (fi == FIW'(FEATURES - 1));
  assign last_row = ((CNW'(row) + CNW'(1)) == count);

  // memories
  logic           t_we;
  logic [TAW-1:0] t_waddr, t_raddr;
  logic [15:0]    t_wdata, t_rdata;
  logic           l_we, l_rdata;
  logic           q_we;
  logic [15:0]    q_rdata;

  assign t_we    = (acc_train && room && pos_lt) || ctl.sweep_en;
  assign t_waddr = ctl.sweep_en ? (sbase + TAW'(sw)) : (wbase + TAW'(pos));
  assign t_wdata = ctl.sweep_en ? 16'd0 : feature_value;
  assign t_raddr = rbase + TAW'(fi);
  assign l_we    = acc_train && last_feature && room;
  assign q_we    = acc_query && pos_lt;

  knnbc_ram #(.WIDTH(16), .DEPTH(MAX_TRAIN_POINTS * FEATURES)) u_train_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  knnbc_ram #(.WIDTH(1), .DEPTH(MAX_TRAIN_POINTS)) u_label_ram (
    .clk(clk), .we(l_we), .waddr(count[LAW-1:0]), .wdata(point_label),
    .raddr(row), .rdata(l_rdata)
  );

  knnbc_ram #(.WIDTH(16), .DEPTH(FEATURES)) u_query_ram (
    .clk(clk), .we(q_we), .waddr(pos[FIW-1:0]), .wdata(feature_value),
    .raddr(fi), .rdata(q_rdata)
  );

  // query entries not written since the query began read as zero
  logic [FEATURES-1:0] qvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= '0;
      count          <= '0;
      wbase          <= '0;
      overflow       <= 1'b0;
      neighbor_count <= knnbc_pkg::NEIGHBOR_COUNT_RST;
      qvalid         <= '0;
    end else begin
      if (cfg_we) neighbor_count <= cfg_data;
      if (ctl.accept && is_clear) begin
        pos   <= '0;
        count <= '0;
        wbase <= '0;
      end else if (acc_train || acc_query) begin
        if (last_feature) pos <= '0;
        else if (pos_lt) pos <= pos + PW'(1);
        if (acc_train && last_feature) begin
          if (room) begin
            count <= count + CNW'(1);
            wbase <= wbase + TAW'(FEATURES);
          end else begin
            overflow <= 1'b1;
          end
        end
        if (q_we) begin
          qvalid <= ((pos == '0) ? '0 : qvalid) |
                    (FEATURES'(1) << pos[FIW-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start_sweep) begin
      sw    <= FIW'(1);
      sbase <= wbase;
    end else if (ctl.sweep_en) begin
      sw <= sw + FIW'(1);
    end
  end

  // scan address generation
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_done <= 1'b1;
    end else if (ctl.start_scan) begin
      issue_done <= (count == '0);
    end else if (iss && row_end && last_row) begin
      issue_done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start_scan) begin
      fi    <= '0;
      row   <= '0;
      rbase <= '0;
    end else if (iss) begin
      if (row_end) begin
        fi    <= '0;
        row   <= row + LAW'(1);
        rbase <= rbase + TAW'(FEATURES);
      end else begin
        fi <= fi + FIW'(1);
      end
    end
  end

  // distance stage
  logic           s1_valid, s1_last;
  logic [FIW-1:0] s1_feat;
  logic [DW-1:0]  acc, sum;
  logic [15:0]    qv;
  logic signed [16:0] diff, ad;

  assign qv   = qvalid[s1_feat] ? q_rdata : 16'd0;
  assign diff = $signed({qv[15], qv}) - $signed({t_rdata[15], t_rdata});
  assign ad   = diff[16] ? -diff : diff;
  assign sum  = acc + DW'(ad[15:0]);

  logic          ins_valid, ins_label;
  logic [DW-1:0] ins_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      ins_valid <= 1'b0;
    end else begin
      s1_valid  <= iss;
      ins_valid <= s1_valid && s1_last;
    end
  end

  always_ff @(posedge clk) begin
    s1_feat <= fi;
    s1_last <= row_end;
    if (ctl.start_scan) begin
      acc <= '0;
    end else if (s1_valid) begin
      acc <= s1_last ? '0 : sum;
    end
    if (s1_valid && s1_last) begin
      ins_dist  <= sum;
      ins_label <= l_rdata;
    end
  end

  // sorted nearest list, equal distances keep the earlier point in front
  logic [DW-1:0]          cdist [MAX_NEIGHBORS];
  logic [MAX_NEIGHBORS-1:0] clab, cval, gt;

  genvar j;
  generate
    for (j = 0; j < MAX_NEIGHBORS; j++) begin : g_cell
      localparam logic [7:0] JV = 8'(j);
      logic en, prev_gt, prev_val, prev_lab;
      logic [DW-1:0] prev_dist;

      assign gt[j] = !cval[j] || (cdist[j] > ins_dist);
      assign en    = ins_valid && ({3'b000, neighbor_count} > JV);

      if (j == 0) begin : g_head
        assign prev_gt   = 1'b0;
        assign prev_val  = 1'b0;
        assign prev_lab  = 1'b0;
        assign prev_dist = '0;
      end else begin : g_body
        assign prev_gt   = gt[j-1];
        assign prev_val  = cval[j-1];
        assign prev_lab  = clab[j-1];
        assign prev_dist = cdist[j-1];
      end

      always_ff @(posedge clk) begin
        if (rst || ctl.start_scan) begin
          cval[j] <= 1'b0;
        end else if (en) begin
          if (prev_gt) cval[j] <= prev_val;
          else if (gt[j]) cval[j] <= 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          if (prev_gt) begin
            cdist[j] <= prev_dist;
            clab[j]  <= prev_lab;
          end else if (gt[j]) begin
            cdist[j] <= ins_dist;
            clab[j]  <= ins_label;
          end
        end
      end
    end
  endgenerate

  // vote, one list entry per cycle
  logic [VIW-1:0] vj;
  logic [CW-1:0]  zeros, used;
  logic [UW-1:0]  used_ext;

  always_ff @(posedge clk) begin
    if (ctl.vote_init) begin
      vj    <= '0;
      zeros <= '0;
      used  <= '0;
    end else if (ctl.vote_en) begin
      vj <= vj + VIW'(1);
      if (cval[vj]) begin
        used <= used + CW'(1);
        if (!clab[vj]) zeros <= zeros + CW'(1);
      end
    end
  end

  assign used_ext = UW'(used);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      prediction       <= !({zeros, 1'b0} > {1'b0, used});
      neighbors_used   <= used_ext[4:0];
      store_overflowed <= overflow;
    end
  end

  assign stat.query_last = is_query && last_feature;
  assign stat.need_sweep = is_train && (pos == '0) && room && (FEATURES > 1);
  assign stat.sweep_last = (sw == FIW'(FEATURES - 1));
  assign stat.issue_done = issue_done;
  assign stat.pipe_empty = !s1_valid && !ins_valid;
  assign stat.vote_last  = (vj == VIW'(MAX_NEIGHBORS - 1));
  assign stat.out_free   = !out_valid || !out_stall;

endmodule

/* rtl/knn_binary_classifier.sv */
// ----------------------------------------------------------------------------
// knn_binary_classifier
// Binary k-nearest-neighbour classifier, Manhattan distance, Q8.8 features
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// cfg     | in        | cfg_we             | cfg_data (neighbour count k)
// in      | in        | in_valid/in_stall  | cmd, feature_value, point_label, last_feature
// out     | out       | out_valid/out_stall| prediction, neighbors_used, store_overflowed
//
// while the first feature of a stored training point is taken, the rest of its
// row in the feature RAM is zeroed one entry per cycle and further input stalls
// a query's last feature starts a scan of the store:
// one feature RAM read per cycle, then one list entry per cycle in the vote
// rst clears control state only; no clearing pass after reset
// in_stall is high while busy; a result waits in the output register under out_stall
module knn_binary_classifier #(
  parameter int MAX_TRAIN_POINTS = 1024,
  parameter int FEATURES         = 16,
  parameter int MAX_NEIGHBORS    = 31
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [15:0] feature_value,
  input  logic               point_label,
  input  logic               last_feature,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               prediction,
  output logic [4:0]         neighbors_used,
  output logic               store_overflowed
);

  knnbc_pkg::ctrl_t ctl;
  knnbc_pkg::stat_t stat;

  knnbc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .stat(stat),
    .in_stall(in_stall), .ctl(ctl)
  );

  knnbc_dpath #(
    .MAX_TRAIN_POINTS(MAX_TRAIN_POINTS),
    .FEATURES(FEATURES),
    .MAX_NEIGHBORS(MAX_NEIGHBORS)
  ) u_dpath (
    .clk(clk), .rst(rst), .ctl(ctl), .stat(stat),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .cmd(cmd), .feature_value(feature_value), .point_label(point_label),
    .last_feature(last_feature),
    .out_valid(out_valid), .out_stall(out_stall), .prediction(prediction),
    .neighbors_used(neighbors_used), .store_overflowed(store_overflowed)
  );

`ifndef SYNTH
  // a result is only loaded when the output register is free
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending transfer");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |=> out_valid)
    else $error("loaded result not presented");

  // no input transfer while a query scan is under way
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.start_scan |=> in_stall)
    else $error("input taken during scan");
`endif

endmodule

/* tb/knn_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_checker
// Watches the configuration, input and result channels of the classifier,
// keeps its own copy of the training store and query buffer, predicts the
// vote for every completed query and compares each result transfer with it
// ----------------------------------------------------------------------------
module knn_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [15:0] feature_value,
  input  logic               point_label,
  input  logic               last_feature,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               prediction,
  input  logic [4:0]         neighbors_used,
  input  logic               store_overflowed,
  output int                 errors,
  output int                 pending
);

  localparam int STORE_DEPTH = 1024;
  localparam int FEAT_NUM    = 16;
  localparam int VOTE_MAX    = 31;

  typedef struct packed {
    logic       pred;
    logic [4:0] used;
    logic       ovf;
  } vote_t;

  logic signed [15:0] train_rows [STORE_DEPTH][FEAT_NUM];
  logic               train_lbls [STORE_DEPTH];
  logic signed [15:0] query_buf  [FEAT_NUM];
  int unsigned        stored;
  int unsigned        feat_pos;
  logic               ovf_flag;
  logic [4:0]         k_reg;
  vote_t              votes_q [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  // nearest-k insertion list, earlier index wins on equal distance
  task automatic take_item(input logic [1:0] c, input logic signed [15:0] v,
                           input logic lbl, input logic lst);
    int unsigned near_d [VOTE_MAX];
    logic        near_l [VOTE_MAX];
    int unsigned kk, used, d, pos, zeros, ones;
    int          diff;
    vote_t       res;
    case (c)
      knnbc_pkg::CMD_CLEAR: begin
        stored   = 0;
        feat_pos = 0;
      end
      knnbc_pkg::CMD_TRAIN: begin
        if (stored < STORE_DEPTH) begin
          if (feat_pos == 0)
            for (int i = 0; i < FEAT_NUM; i++) train_rows[stored][i] = '0;
          if (feat_pos < FEAT_NUM) train_rows[stored][feat_pos] = v;
        end
        if (feat_pos < FEAT_NUM) feat_pos++;
        if (lst) begin
          if (stored < STORE_DEPTH) begin
            train_lbls[stored] = lbl;
            stored++;
          end else begin
            ovf_flag = 1'b1;
          end
          feat_pos = 0;
        end
      end
      knnbc_pkg::CMD_QUERY: begin
        if (feat_pos == 0)
          for (int i = 0; i < FEAT_NUM; i++) query_buf[i] = '0;
        if (feat_pos < FEAT_NUM) begin
          query_buf[feat_pos] = v;
          feat_pos++;
        end
        if (lst) begin
          feat_pos = 0;
          kk = (k_reg > VOTE_MAX) ? VOTE_MAX : k_reg;
          used = 0;
          for (int p = 0; p < stored; p++) begin
            d = 0;
            for (int i = 0; i < FEAT_NUM; i++) begin
              diff = int'(query_buf[i]) - int'(train_rows[p][i]);
              d += (diff < 0) ? -diff : diff;
            end
            pos = 0;
            while (pos < used && near_d[pos] <= d) pos++;
            if (pos < kk) begin
              if (used < kk) used++;
              for (int j = int'(used) - 1; j > int'(pos); j--) begin
                near_d[j] = near_d[j-1];
                near_l[j] = near_l[j-1];
              end
              near_d[pos] = d;
              near_l[pos] = train_lbls[p];
            end
          end
          zeros = 0;
          ones  = 0;
          for (int j = 0; j < used; j++)
            if (near_l[j]) ones++;
            else zeros++;
          res.pred = (zeros > ones) ? 1'b0 : 1'b1;
          res.used = used[4:0];
          res.ovf  = ovf_flag;
          votes_q = {votes_q, res};
        end
      end
      default: ;
    endcase
  endtask

  // sampled mid-cycle: a transfer seen here happens at the next rising edge
  always @(negedge clk) begin
    vote_t want;
    if (rst) begin
      stored   = 0;
      feat_pos = 0;
      ovf_flag = 1'b0;
      k_reg    = knnbc_pkg::NEIGHBOR_COUNT_RST;
      for (int i = 0; i < FEAT_NUM; i++) query_buf[i] = '0;
      votes_q.delete();
    end else begin
      if (cfg_we) k_reg = cfg_data;
      if (in_valid && !in_stall)
        take_item(cmd, feature_value, point_label, last_feature);
      if (out_valid && !out_stall) begin
        if (votes_q.size() == 0) begin
          report("unexpected result transfer", 1, 0);
        end else begin
          want = votes_q.pop_front();
          if (prediction !== want.pred) report("prediction", prediction, want.pred);
          if (neighbors_used !== want.used)
            report("neighbors_used", neighbors_used, want.used);
          if (store_overflowed !== want.ovf)
            report("store_overflowed", store_overflowed, want.ovf);
        end
      end
    end
    pending = votes_q.size();
  end

endmodule

/* tb/tb_knn_binary_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_knn_binary_classifier
// Drives training points, queries, clears and ignored commands into the
// classifier under several neighbour counts and leaves checking of every
// vote to knn_checker
// ----------------------------------------------------------------------------
module tb_knn_binary_classifier;

  localparam logic [1:0] CMD_NONE    = 2'd3;
  localparam int         STORE_DEPTH = 1024;
  localparam int         IDLE_LIMIT  = 100000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [4:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         cmd = CMD_NONE;
  logic signed [15:0] feature_value = '0;
  logic               point_label = 1'b0;
  logic               last_feature = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               prediction;
  logic [4:0]         neighbors_used;
  logic               store_overflowed;
  int                 errors;
  int                 pending;

  int unsigned train_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  knn_binary_classifier u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .feature_value(feature_value), .point_label(point_label),
    .last_feature(last_feature), .out_valid(out_valid), .out_stall(out_stall),
    .prediction(prediction), .neighbors_used(neighbors_used),
    .store_overflowed(store_overflowed)
  );

  knn_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .feature_value(feature_value), .point_label(point_label),
    .last_feature(last_feature), .out_valid(out_valid), .out_stall(out_stall),
    .prediction(prediction), .neighbors_used(neighbors_used),
    .store_overflowed(store_overflowed), .errors(errors), .pending(pending)
  );

  // transfer counting and watchdog
  always @(negedge clk) begin
    if (out_valid && !out_stall) results_seen++;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("tb_knn_binary_classifier: errors");
        $finish;
      end
    end
  end

  // result side: random stall, a calm window, and one long hold-off
  initial begin
    int unsigned cyc;
    bit held;
    cyc  = 0;
    held = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!held && results_seen >= 15) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else if (cyc > 3000 && cyc < 9000) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 27);
      end
    end
  end

  task automatic send_item(input logic [1:0] c, input logic signed [15:0] v,
                           input logic lbl, input logic lst);
    bit taken;
    bit calm;
    calm = (items_sent >= 200 && items_sent < 320);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= c;
    feature_value <= v;
    point_label   <= lbl;
    last_feature  <= lst;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (c != CMD_NONE) items_sent++;
  endtask

  function automatic logic signed [15:0] pick_feature();
    if ($urandom_range(99) < 35) return 16'($urandom_range(0, 65535));
    return 16'($signed($urandom_range(0, 6)) - 3);
  endfunction

  // whole point of n features, label carried on the last one
  task automatic send_point(input logic [1:0] c, input int n, input logic lbl);
    for (int i = 0; i < n; i++)
      send_item(c, pick_feature(), (i == n - 1) ? lbl : 1'($urandom), i == n - 1);
    if (c == knnbc_pkg::CMD_TRAIN && train_count < STORE_DEPTH) train_count++;
  endtask

  task automatic send_clear();
    send_item(knnbc_pkg::CMD_CLEAR, pick_feature(), 1'($urandom), 1'($urandom));
    train_count = 0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_k(input logic [4:0] k);
    cfg_we   <= 1'b1;
    cfg_data <= k;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_traffic(input int unsigned count);
    int unsigned stop;
    int unsigned r;
    stop = items_sent + count;
    while (items_sent < stop) begin
      r = $urandom_range(99);
      if (train_count >= 48) send_clear();
      else if (r < 45)
        send_point(knnbc_pkg::CMD_TRAIN, $urandom_range(1, 18), 1'($urandom));
      else if (r < 82)
        send_point(knnbc_pkg::CMD_QUERY, $urandom_range(1, 18), 1'($urandom));
      else if (r < 87) send_clear();
      else if (r < 93) send_item(CMD_NONE, pick_feature(), 1'($urandom), 1'($urandom));
      else begin
        // abandoned point, cut short by a clear
        for (int i = $urandom_range(1, 5); i > 0; i--)
          send_item(($urandom_range(1)) ? knnbc_pkg::CMD_QUERY : knnbc_pkg::CMD_TRAIN,
                    pick_feature(), 1'($urandom), 1'b0);
        send_clear();
      end
    end
  endtask

  initial begin
    logic [4:0] k_set [5];
    k_set = '{5'd1, 5'd31, 5'd0, 5'd7, 5'd11};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store, extreme distance, missing and extra features, ignored code
    send_item(knnbc_pkg::CMD_QUERY, 16'sd5, 1'b0, 1'b1);
    for (int i = 0; i < 16; i++)
      send_item(knnbc_pkg::CMD_TRAIN, 16'sh7fff, 1'b0, i == 15);
    for (int i = 0; i < 16; i++)
      send_item(knnbc_pkg::CMD_QUERY, 16'sh8000, 1'b1, i == 15);
    send_item(knnbc_pkg::CMD_TRAIN, 16'sh8000, 1'b1, 1'b1);
    for (int i = 0; i < 18; i++)
      send_item(knnbc_pkg::CMD_TRAIN, 16'sh0100, 1'b1, i == 17);
    send_item(CMD_NONE, 16'sh7fff, 1'b1, 1'b1);
    send_item(knnbc_pkg::CMD_QUERY, 16'sh0000, 1'b0, 1'b1);
    send_item(knnbc_pkg::CMD_CLEAR, 16'sh0000, 1'b0, 1'b0);
    send_item(knnbc_pkg::CMD_QUERY, 16'sh0000, 1'b0, 1'b1);
    train_count = 0;
    random_traffic(90);
    drain();

    foreach (k_set[i]) begin
      write_k(k_set[i]);
      random_traffic(75);
      drain();
    end
    write_k(5'($urandom_range(1, 31)));
    random_traffic(40);

    send_clear();
    random_traffic(20);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("tb_knn_binary_classifier: clean");
    end else begin
      $display("tb_knn_binary_classifier: errors");
    end
    $finish;
  end

endmodule
